FILE: sv/roch_pkg.sv
// ----------------------------------------------------------------------------
// roch_pkg
// shared types and constants of the ray to oriented box closest hit block
// ----------------------------------------------------------------------------
`default_nettype none

package roch_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DIST_WIDTH_DEF  = 40;
   localparam int ID_WIDTH_DEF    = 16;
   localparam int DIR_WIDTH       = 18;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int PAR_SCALE       = 1000;
   localparam int FAR_RESET_UNITS = 100000;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_ORIGIN_Z  = 3'd2,
      CSR_DIR_X     = 3'd3,
      CSR_DIR_Y     = 3'd4,
      CSR_DIR_Z     = 3'd5,
      CSR_FAR_LIMIT = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DIV_SETUP,
      ST_DIV,
      ST_UPDATE,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic take;
      logic mul_en;
      logic check;
      logic div_load;
      logic div_en;
      logic update;
      logic finish;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: sv/ray_obb_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_obb_closest_hit
// slab test of a ray against oriented boxes with closest hit tracking
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  slab item, tlast last_axis, tuser last_box
//  rsp      out        rsp_tvalid/rsp_tready  box result, tlast cast_done
//  csr      in         csr_we                 register index and write data
//
//  a slab passes an accept state, a multiply state on one shared multiplier, a check
//  state, two divisions of a setup and a divide state each on one restoring divider,
//  an update and a finish state; a parallel slab goes from check to finish and a
//  slab of a box already missed goes from accept straight to finish
//  reset is synchronous and restores the register defaults, slab, best hit and state
//  a finished result waits in the output register; the next slab is taken
//  while it waits, and only a second result stalls on rsp_tready
// ----------------------------------------------------------------------------
`default_nettype none

module ray_obb_closest_hit #(
   parameter int COORD_WIDTH = roch_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = roch_pkg::FRAC_BITS_DEF,
   parameter int DIST_WIDTH  = roch_pkg::DIST_WIDTH_DEF,
   parameter int ID_WIDTH    = roch_pkg::ID_WIDTH_DEF,
   localparam int REQ_RAW    = 5 * COORD_WIDTH + 3 * roch_pkg::DIR_WIDTH + ID_WIDTH,
   localparam int REQ_W      = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW    = 2 * ID_WIDTH + 2 * (DIST_WIDTH - 1) + 2,
   localparam int RSP_W      = ((RSP_RAW + 7) / 8) * 8,
   localparam int CSR_W0     = (COORD_WIDTH > roch_pkg::DIR_WIDTH) ? COORD_WIDTH
                                                                  : roch_pkg::DIR_WIDTH,
   localparam int CSR_W      = (CSR_W0 > DIST_WIDTH - 1) ? CSR_W0 : DIST_WIDTH - 1
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // centre_x, centre_y, centre_z, axis_x, axis_y, axis_z, extent_low,
   // extent_high, box_id, zero fill
   input  wire logic [REQ_W-1:0]                      req_tdata,
   input  wire logic                                  req_tlast,
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // hit_box_id, box_hit, box_distance, best_valid, best_id, best_distance, zero fill
   output logic [RSP_W-1:0]                           rsp_tdata,
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_we,
   input  wire logic [roch_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  wire logic [CSR_W-1:0]                      csr_wdata
);

   import roch_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = DIST_WIDTH;
   localparam int DRW    = DIR_WIDTH;
   localparam int PROD_W = CW + 1 + DRW;
   localparam int E_W    = PROD_W + 2;
   localparam int F_W    = 2 * DRW + 2;
   localparam int LO_W   = CW + FRAC_BITS;
   localparam int NUM_W  = ((E_W > LO_W) ? E_W : LO_W) + 1;
   localparam int FA_W   = F_W + 10;
   localparam int SH     = DW - 1 - FRAC_BITS;
   localparam int IT_W   = $clog2(DW);

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic signed [CW-1:0]  origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [DRW-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [DW-2:0]         far_limit_ff;

   logic signed [DRW-1:0] axis_ff [3];
   logic signed [CW:0]    diff_ff [3];
   logic signed [CW-1:0]  lo_ff, hi_ff;
   logic [ID_WIDTH-1:0]   id_ff;
   logic                  last_axis_ff, last_box_ff;

   logic [2:0]               cnt_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [E_W-1:0]    e_ff;
   logic signed [F_W-1:0]    f_ff;
   logic signed [DRW-1:0]    mul_a;
   logic signed [CW:0]       mul_b;

   logic signed [NUM_W-1:0]  e_ext, lo_s, hi_s, num_lo, num_hi, num_sel;
   logic [F_W-1:0]           fa;
   logic [FA_W-1:0]          fa_scaled;
   logic                     parallel, par_miss;

   logic [NUM_W-1:0]         un;
   logic [NUM_W+FRAC_BITS-1:0] dwide;
   logic [F_W-1:0]           ud_ff, rem_ff;
   logic [F_W:0]             r2;
   logic [DW-2:0]            dlow_ff, q_ff, q_next;
   logic                     neg_ff, sat_ff, sel_ff;
   logic [IT_W-1:0]          it_ff;
   logic signed [DW-1:0]     quot, t1_ff, t2_ff, tmin, tmax, far_new, near_new;

   logic signed [DW-1:0]     near_t_ff, far_t_ff, best_t_ff;
   logic                     box_missed_ff, best_found_ff;
   logic [ID_WIDTH-1:0]      best_box_ff;
   logic                     hit, better, bf_new;
   logic [ID_WIDTH-1:0]      bb_new;
   logic signed [DW-1:0]     bt_new;

   logic                     rsp_valid_ff, rsp_last_ff;
   logic [RSP_W-1:0]         rsp_data_ff;
   logic                     out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = box_missed_ff ? ST_FINAL : ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == 3'd6) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:     state_in = parallel ? ST_FINAL : ST_DIV_SETUP;
         ST_DIV_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (it_ff == '0) begin
               state_in = sel_ff ? ST_UPDATE : ST_DIV_SETUP;
            end
         end
         ST_UPDATE:    state_in = ST_FINAL;
         ST_FINAL: begin
            if (!last_axis_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:      ctrl.take     = 1'b1;
         ST_MUL:       ctrl.mul_en   = 1'b1;
         ST_CHECK:     ctrl.check    = 1'b1;
         ST_DIV_SETUP: ctrl.div_load = 1'b1;
         ST_DIV:       ctrl.div_en   = 1'b1;
         ST_UPDATE:    ctrl.update   = 1'b1;
         ST_FINAL:     ctrl.finish   = !last_axis_ff || out_free;
         default:      ctrl = '0;
      endcase
   end

   assign req_tready = ctrl.take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         dir_x_ff     <= '0;
         dir_y_ff     <= '0;
         dir_z_ff     <= DRW'(1) <<< FRAC_BITS;
         far_limit_ff <= (DW-1)'(FAR_RESET_UNITS) << FRAC_BITS;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata[CW-1:0];
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata[CW-1:0];
            CSR_ORIGIN_Z:  origin_z_ff  <= csr_wdata[CW-1:0];
            CSR_DIR_X:     dir_x_ff     <= csr_wdata[DRW-1:0];
            CSR_DIR_Y:     dir_y_ff     <= csr_wdata[DRW-1:0];
            CSR_DIR_Z:     dir_z_ff     <= csr_wdata[DRW-1:0];
            CSR_FAR_LIMIT: far_limit_ff <= csr_wdata[DW-2:0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (ctrl.take && req_tvalid) begin
         diff_ff[0]   <= (CW+1)'(signed'(req_tdata[CW-1:0])) - (CW+1)'(origin_x_ff);
         diff_ff[1]   <= (CW+1)'(signed'(req_tdata[2*CW-1:CW])) - (CW+1)'(origin_y_ff);
         diff_ff[2]   <= (CW+1)'(signed'(req_tdata[3*CW-1:2*CW])) - (CW+1)'(origin_z_ff);
         axis_ff[0]   <= req_tdata[3*CW+DRW-1:3*CW];
         axis_ff[1]   <= req_tdata[3*CW+2*DRW-1:3*CW+DRW];
         axis_ff[2]   <= req_tdata[3*CW+3*DRW-1:3*CW+2*DRW];
         lo_ff        <= req_tdata[4*CW+3*DRW-1:3*CW+3*DRW];
         hi_ff        <= req_tdata[5*CW+3*DRW-1:4*CW+3*DRW];
         id_ff        <= req_tdata[REQ_RAW-1:5*CW+3*DRW];
         last_axis_ff <= req_tlast;
         last_box_ff  <= req_tuser;
      end
   end

   // shared multiplier operands
   always_comb begin
      case (cnt_ff)
         3'd0:    begin mul_a = axis_ff[0]; mul_b = diff_ff[0]; end
         3'd1:    begin mul_a = axis_ff[1]; mul_b = diff_ff[1]; end
         3'd2:    begin mul_a = axis_ff[2]; mul_b = diff_ff[2]; end
         3'd3:    begin mul_a = dir_x_ff;   mul_b = (CW+1)'(axis_ff[0]); end
         3'd4:    begin mul_a = dir_y_ff;   mul_b = (CW+1)'(axis_ff[1]); end
         3'd5:    begin mul_a = dir_z_ff;   mul_b = (CW+1)'(axis_ff[2]); end
         default: begin mul_a = '0;         mul_b = '0; end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         cnt_ff <= '0;
         e_ff   <= '0;
         f_ff   <= '0;
      end else if (ctrl.mul_en) begin
         cnt_ff  <= cnt_ff + 3'd1;
         prod_ff <= prod_in;
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd3) begin
            e_ff <= e_ff + E_W'(prod_ff);
         end else if (cnt_ff >= 3'd4) begin
            f_ff <= f_ff + F_W'(prod_ff);
         end
      end
   end

   // parallel test and plane numerators
   always_comb begin
      e_ext     = NUM_W'(e_ff);
      lo_s      = NUM_W'(lo_ff) <<< FRAC_BITS;
      hi_s      = NUM_W'(hi_ff) <<< FRAC_BITS;
      num_lo    = e_ext + lo_s;
      num_hi    = e_ext + hi_s;
      num_sel   = sel_ff ? num_hi : num_lo;
      fa        = f_ff[F_W-1] ? F_W'(-f_ff) : F_W'(f_ff);
      fa_scaled = FA_W'(fa) * FA_W'(PAR_SCALE);
      parallel  = !(fa_scaled > (FA_W'(1) << (2 * FRAC_BITS)));
      par_miss  = (lo_s > e_ext) || (hi_s < e_ext);
      un        = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
      dwide     = {un, {FRAC_BITS{1'b0}}};
      r2        = {rem_ff, dlow_ff[DW-2]};
      q_next    = {q_ff[DW-3:0], (r2 >= {1'b0, ud_ff})};
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (ctrl.check) begin
         sel_ff <= 1'b0;
      end else if (ctrl.div_load) begin
         ud_ff   <= fa;
         neg_ff  <= num_sel[NUM_W-1] ^ f_ff[F_W-1];
         sat_ff  <= (un >> SH) >= NUM_W'(fa);
         rem_ff  <= F_W'(un >> SH);
         dlow_ff <= dwide[DW-2:0];
         q_ff    <= '0;
         it_ff   <= IT_W'(DW - 2);
      end else if (ctrl.div_en) begin
         if (r2 >= {1'b0, ud_ff}) begin
            rem_ff <= F_W'(r2 - {1'b0, ud_ff});
            q_ff   <= {q_ff[DW-3:0], 1'b1};
         end else begin
            rem_ff <= F_W'(r2);
            q_ff   <= {q_ff[DW-3:0], 1'b0};
         end
         dlow_ff <= {dlow_ff[DW-3:0], 1'b0};
         it_ff   <= it_ff - IT_W'(1);
         if (it_ff == '0) begin
            sel_ff <= 1'b1;
         end
      end
   end

   // quotient including the bit decided in the final cycle
   always_comb begin
      if (sat_ff) begin
         quot = neg_ff ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         quot = neg_ff ? -signed'({1'b0, q_next}) : signed'({1'b0, q_next});
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.div_en && it_ff == '0) begin
         if (sel_ff) begin
            t2_ff <= quot;
         end else begin
            t1_ff <= quot;
         end
      end
   end

   // interval update and closest hit
   always_comb begin
      tmin     = (t1_ff > t2_ff) ? t2_ff : t1_ff;
      tmax     = (t1_ff > t2_ff) ? t1_ff : t2_ff;
      far_new  = (tmax < far_t_ff) ? tmax : far_t_ff;
      near_new = (tmin > near_t_ff) ? tmin : near_t_ff;
      hit      = !box_missed_ff;
      better   = hit && (!best_found_ff || near_t_ff < best_t_ff);
      bf_new   = best_found_ff || hit;
      bb_new   = better ? id_ff : best_box_ff;
      bt_new   = better ? near_t_ff : best_t_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_t_ff     <= '0;
         far_t_ff      <= DW'(FAR_RESET_UNITS) << FRAC_BITS;
         box_missed_ff <= 1'b0;
         best_found_ff <= 1'b0;
         best_box_ff   <= '0;
         best_t_ff     <= '0;
      end else if (ctrl.check) begin
         if (parallel && par_miss) begin
            box_missed_ff <= 1'b1;
         end
      end else if (ctrl.update) begin
         far_t_ff  <= far_new;
         near_t_ff <= near_new;
         if (far_new < near_new) begin
            box_missed_ff <= 1'b1;
         end
      end else if (ctrl.finish && last_axis_ff) begin
         near_t_ff     <= '0;
         far_t_ff      <= signed'({1'b0, far_limit_ff});
         box_missed_ff <= 1'b0;
         if (last_box_ff) begin
            best_found_ff <= 1'b0;
            best_box_ff   <= '0;
            best_t_ff     <= '0;
         end else begin
            best_found_ff <= bf_new;
            best_box_ff   <= bb_new;
            best_t_ff     <= bt_new;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish && last_axis_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish && last_axis_ff) begin
         rsp_last_ff <= last_box_ff;
         rsp_data_ff <= RSP_W'({
            bf_new ? bt_new[DW-2:0] : {(DW-1){1'b0}},
            bf_new ? bb_new : {ID_WIDTH{1'b0}},
            bf_new,
            hit ? near_t_ff[DW-2:0] : {(DW-1){1'b0}},
            hit,
            id_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while a slab is in flight");

   a_near_positive: assert property (@(posedge clock) disable iff (reset)
      !near_t_ff[DW-1])
      else $error("near distance went negative");

   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[ID_WIDTH+DW] |->
      rsp_tdata[RSP_RAW-1:ID_WIDTH+DW+1] == '0)
      else $error("best fields set without a best hit");
`endif

endmodule

`default_nettype wire
